// ===== rtl/core/pba_pkg.sv =====
package pba_pkg;

  localparam int unsigned ReqW    = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned PageIdW = 6;

  localparam logic [15:0] PageSizeReset = 16'd4096;

  typedef enum logic [StatusW-1:0] {
    ST_GRANTED      = 2'd0,
    ST_INVALID_SIZE = 2'd1,
    ST_OUT_OF_PAGES = 2'd2
  } status_e;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_CHECK   = 6'b000100,
    S_ADV     = 6'b001000,
    S_ADV_CHK = 6'b010000,
    S_DONE    = 6'b100000
  } state_e;

endpackage

// ===== rtl/core/paged_bump_allocator_top.sv =====
// From accept to result valid: a rejected request goes straight to the result register;
// otherwise each open page compared takes a fill-level read and then a compare, a new page
// is opened if none fits, the not-full pointer then reads and checks each page it examines,
// and the result is registered. Out of pages follows the compares with no page opened.
// Throughput: one transaction in flight; the next is taken the cycle after its result
// enters the output register. Reset: asynchronous, active low; page 0 open and empty, 4096.
module paged_bump_allocator_top
  import pba_pkg::*;
#(
  parameter int unsigned MAX_PAGES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration: bytes per page
  input  logic        cfg_wr_en_i,
  input  logic [15:0] cfg_wr_data_i,
  // request stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] request_bytes
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [1:0] status, [7:2] page_index, [23:8] byte_offset
);

  // AW indexes the fill-level memory, CW counts pages up to MAX_PAGES itself.
  localparam int unsigned AW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
  localparam int unsigned CW = $clog2(MAX_PAGES + 1);
  localparam logic [CW-1:0] MaxPagesC = CW'(MAX_PAGES);

  state_e state_q, state_d;

  logic [15:0]   page_len_q;
  logic [CW-1:0] pages_in_use_q, pages_in_use_d;
  logic [CW-1:0] first_unfull_q, first_unfull_d;
  logic [CW-1:0] page_q, page_d;
  logic [15:0]   req_q, req_d;

  // Page 0 is open from reset but never written until its first grant:
  // read it as empty until then. Every other page is written when opened.
  logic page0_wr_q, page0_wr_d;

  // Working copy of the answer while the transaction is processed.
  status_e       wk_status_q, wk_status_d;
  logic [5:0]    wk_page_q, wk_page_d;
  logic [15:0]   wk_off_q, wk_off_d;

  // Result register parts the block from the output side.
  logic          out_valid_q, out_valid_d;
  status_e       res_status_q, res_status_d;
  logic [5:0]    res_page_q, res_page_d;
  logic [15:0]   res_off_q, res_off_d;

  // Fill-level memory: one write port, one registered read port.
  logic [15:0]   fill_mem [MAX_PAGES];
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [15:0]   mem_wd;
  logic          mem_re;
  logic [AW-1:0] mem_ra;
  logic [15:0]   rd_data_q;
  logic          rd_zero_q;

  logic [15:0]   fill_rd;
  logic [15:0]   room;
  logic          in_xfer;

  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {res_off_q, res_page_q, res_status_q};

  // Free room in the page just read; saturates at zero when the page size
  // was lowered below the fill level.
  assign fill_rd = rd_zero_q ? 16'd0 : rd_data_q;
  assign room    = (fill_rd >= page_len_q) ? 16'd0 : (page_len_q - fill_rd);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      fill_mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_q <= fill_mem[mem_ra];
      rd_zero_q <= (mem_ra == '0) && !page0_wr_q;
    end
  end

  always_comb begin
    state_d        = state_q;
    pages_in_use_d = pages_in_use_q;
    first_unfull_d = first_unfull_q;
    page_d         = page_q;
    req_d          = req_q;
    page0_wr_d     = page0_wr_q;
    wk_status_d    = wk_status_q;
    wk_page_d      = wk_page_q;
    wk_off_d       = wk_off_q;
    out_valid_d    = out_valid_q;
    res_status_d   = res_status_q;
    res_page_d     = res_page_q;
    res_off_d      = res_off_q;
    mem_we         = 1'b0;
    mem_wa         = page_q[AW-1:0];
    mem_wd         = '0;
    mem_re         = 1'b0;
    mem_ra         = page_q[AW-1:0];

    // Drop the result once the output side takes it.
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          req_d  = s_axis_tdata_i;
          page_d = first_unfull_q;
          if (s_axis_tdata_i == '0 || s_axis_tdata_i > page_len_q) begin
            wk_status_d = ST_INVALID_SIZE;
            wk_page_d   = '0;
            wk_off_d    = '0;
            state_d     = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (page_q >= pages_in_use_q) begin
          // No open page fits: open a new one or fail.
          if (pages_in_use_q >= MaxPagesC) begin
            wk_status_d = ST_OUT_OF_PAGES;
            wk_page_d   = '0;
            wk_off_d    = '0;
            state_d     = S_DONE;
          end else begin
            mem_we         = 1'b1;
            mem_wa         = pages_in_use_q[AW-1:0];
            mem_wd         = req_q;
            if (pages_in_use_q == '0) begin
              page0_wr_d = 1'b1;
            end
            pages_in_use_d = pages_in_use_q + 1'b1;
            wk_status_d    = ST_GRANTED;
            wk_page_d      = 6'(pages_in_use_q);
            wk_off_d       = '0;
            state_d        = S_ADV;
          end
        end else begin
          mem_re  = 1'b1;
          state_d = S_CHECK;
        end
      end

      S_CHECK: begin
        if (room >= req_q) begin
          mem_we       = 1'b1;
          mem_wd       = fill_rd + req_q;
          if (page_q == '0) begin
            page0_wr_d = 1'b1;
          end
          wk_status_d = ST_GRANTED;
          wk_page_d   = 6'(page_q);
          wk_off_d    = fill_rd;
          state_d     = S_ADV;
        end else begin
          page_d  = page_q + 1'b1;
          state_d = S_SCAN;
        end
      end

      S_ADV: begin
        // Move the not-full pointer past full pages; the write above has
        // already landed, so the read sees the new fill level.
        if (first_unfull_q >= pages_in_use_q) begin
          state_d = S_DONE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = first_unfull_q[AW-1:0];
          state_d = S_ADV_CHK;
        end
      end

      S_ADV_CHK: begin
        if (room == '0) begin
          first_unfull_d = first_unfull_q + 1'b1;
          state_d        = S_ADV;
        end else begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the result register is free, then load it.
        if (!out_valid_d) begin
          out_valid_d  = 1'b1;
          res_status_d = wk_status_q;
          res_page_d   = wk_page_q;
          res_off_d    = wk_off_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      page_len_q     <= PageSizeReset;
      pages_in_use_q <= CW'(1);
      first_unfull_q <= '0;
      page0_wr_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      pages_in_use_q <= pages_in_use_d;
      first_unfull_q <= first_unfull_d;
      page0_wr_q     <= page0_wr_d;
      out_valid_q    <= out_valid_d;
      if (cfg_wr_en_i) begin
        page_len_q <= cfg_wr_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    page_q       <= page_d;
    req_q        <= req_d;
    wk_status_q  <= wk_status_d;
    wk_page_q    <= wk_page_d;
    wk_off_q     <= wk_off_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    res_off_q    <= res_off_d;
  end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pba_pkg::*;

  localparam int unsigned MaxPages = 64;

  // Result layout on m_axis_tdata: status lowest, then page, then offset.
  typedef struct packed {
    logic [15:0] offset;
    logic [5:0]  page;
    status_e     status;
  } alloc_result_t;

  // A queued request; top_off asks the driver to size it to the exact room
  // left in the lowest page that still has room, at the moment it goes out.
  typedef struct {
    logic [15:0] nbytes;
    bit          top_off;
  } alloc_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [15:0] cfg_wr_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [15:0] s_axis_tdata_i = '0;   // [15:0] request_bytes
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;        // [1:0] status, [7:2] page_index, [23:8] byte_offset

  paged_bump_allocator_top #(
    .MAX_PAGES(MaxPages)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Arena shadow: fill level per page, open page count, lowest page with room.
  // ---------------------------------------------------------------------------
  logic [15:0] pg_fill [MaxPages];
  int unsigned pg_open = 1;
  int unsigned pg_first_free = 0;
  logic [15:0] pg_size = PageSizeReset;

  alloc_req_t    pend_q[$];     // requests not yet handed to the block
  alloc_result_t grant_q[$];    // predicted results, oldest first
  int unsigned   errors = 0;

  initial begin
    for (int i = 0; i < MaxPages; i++) pg_fill[i] = '0;
  end

  // Free room of a page; a page filled past a lowered page size has none.
  function automatic int unsigned room_of(int unsigned p);
    return (pg_fill[p] >= pg_size) ? 0 : int'(pg_size) - int'(pg_fill[p]);
  endfunction

  // Work out the answer to one request and commit it to the shadow arena.
  function automatic alloc_result_t predict_alloc(logic [15:0] nbytes);
    alloc_result_t r;
    int unsigned p;
    r = '{offset: 16'd0, page: 6'd0, status: ST_INVALID_SIZE};
    if (nbytes == 16'd0 || nbytes > pg_size) return r;
    p = pg_first_free;
    while (p < pg_open && room_of(p) < nbytes) p++;
    if (p >= pg_open) begin
      if (pg_open >= MaxPages) begin
        r.status = ST_OUT_OF_PAGES;
        return r;
      end
      p = pg_open;
      pg_fill[p] = '0;
      pg_open++;
    end
    r.status = ST_GRANTED;
    r.page   = p[5:0];
    r.offset = pg_fill[p];
    pg_fill[p] = pg_fill[p] + nbytes;
    // Skip every page that is now completely full.
    while (pg_first_free < pg_open && room_of(pg_first_free) == 0) pg_first_free++;
    return r;
  endfunction

  function automatic logic [15:0] top_off_bytes();
    int unsigned r;
    r = (pg_first_free < pg_open) ? room_of(pg_first_free) : int'(pg_size);
    return (r == 0) ? 16'd1 : r[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps, some gapless runs.
  // Predict each transaction as it is accepted, before the next is sized.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : req_driver
    alloc_req_t  nxt;
    int unsigned burst_left;
    int unsigned gap_left;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        grant_q.push_back(predict_alloc(s_axis_tdata_i));
      end
      // Hold the current request until it is taken.
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid_i <= 1'b0;
        end else if (pend_q.size() > 0) begin
          nxt = pend_q.pop_front();
          if (nxt.top_off) nxt.nbytes = top_off_bytes();
          s_axis_tdata_i  <= nxt.nbytes;
          s_axis_tvalid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 16);
            gap_left   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result sink: rotate a 16-bit ready pattern, reloading it when its age count runs out.
  // Patterns are never all zero, so a stall always ends, even across a reload.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_sink
    logic [15:0] ready_pat;
    int unsigned pat_age;
    if (!rst_ni) begin
      ready_pat = 16'hFFFF;
      pat_age   = 0;
      m_axis_tready_i <= 1'b0;
    end else begin
      if (pat_age == 0) begin
        case ($urandom_range(3))
          0: ready_pat = 16'hFFFF;
          1: ready_pat = 16'h0001 << $urandom_range(15);
          default: ready_pat = 16'($urandom) | 16'h0001;
        endcase
        pat_age = 64;
      end
      pat_age--;
      m_axis_tready_i <= ready_pat[0];
      ready_pat = {ready_pat[0], ready_pat[15:1]};
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted transaction with the oldest grant.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    alloc_result_t got;
    alloc_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = alloc_result_t'(m_axis_tdata_o);
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $time, m_axis_tdata_o);
        errors++;
      end else begin
        want = grant_q.pop_front();
        if (got.status != want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.page != want.page) begin
          $display("%0t: page_index expected %0d actual %0d", $time, want.page, got.page);
          errors++;
        end
        if (got.offset != want.offset) begin
          $display("%0t: byte_offset expected %0d actual %0d", $time, want.offset,
                   got.offset);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_req(logic [15:0] nbytes);
    pend_q.push_back('{nbytes: nbytes, top_off: 1'b0});
  endtask

  // Sample at the falling edge so every update of the rising edge has landed.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pend_q.size() != 0 || s_axis_tvalid_i || grant_q.size() != 0);
  endtask

  // Write the page length only with the arena idle; mirror it into the shadow.
  task automatic write_page_len(logic [15:0] val);
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= val;
    @(posedge clk_i);
    cfg_wr_en_i   <= 1'b0;
    pg_size = val;
  endtask

  // Mostly small fits, some full-range fits, zero, oversize and exact top-offs.
  task automatic random_phase(logic [15:0] ps, int unsigned count, int unsigned small_max);
    int unsigned pick;
    int unsigned lim;
    alloc_req_t  item;
    write_page_len(ps);
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      item.top_off = 1'b0;
      if (pick < 4) begin
        item.top_off = 1'b1;
        item.nbytes  = '0;
      end else if (pick < 8) begin
        item.nbytes = '0;
      end else if (pick < 14) begin
        item.nbytes = (ps == 16'hFFFF) ? 16'h0 : 16'($urandom_range(65535, int'(ps) + 1));
      end else if (pick < 64) begin
        lim = (int'(ps) < small_max) ? int'(ps) : small_max;
        item.nbytes = 16'($urandom_range(1, lim));
      end else begin
        item.nbytes = 16'($urandom_range(1, int'(ps)));
      end
      pend_q.push_back(item);
    end
    wait_idle();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset page size: exact fit fills page 0, one byte over is rejected.
    push_req(16'd4096);
    push_req(16'd4097);
    wait_idle();

    // Zero page size rejects everything.
    write_page_len(16'd0);
    push_req(16'd0);
    push_req(16'd1);
    push_req(16'hFFFF);
    push_req(16'h8000);
    wait_idle();

    // Largest page size: full pages, alternating bit patterns, pointer skips.
    write_page_len(16'hFFFF);
    push_req(16'hFFFF);
    push_req(16'd0);
    push_req(16'd1);
    push_req(16'hFFFE);
    push_req(16'h5555);
    push_req(16'hAAAA);
    push_req(16'd100);
    wait_idle();

    // Back to 4096, leaving a page part filled above the next page size.
    write_page_len(16'd4096);
    push_req(16'd4097);
    push_req(16'd200);
    push_req(16'd4000);
    push_req(16'd4096);
    wait_idle();

    // Lower page size under existing fill levels: those pages count as full.
    write_page_len(16'd50);
    push_req(16'd20);
    push_req(16'd30);
    push_req(16'd51);
    push_req(16'd1);
    wait_idle();

    // Random part; smallest page size near the end to drive the arena out of pages.
    random_phase(16'd4096, 250, 256);
    random_phase(16'($urandom_range(1, 65535)), 200, 1024);
    random_phase(16'hFFFF, 200, 4096);
    random_phase(16'd300, 150, 40);
    random_phase(16'($urandom_range(1, 1000)), 150, 64);
    random_phase(16'd1, 150, 1);
    random_phase(16'hFFFF, 50, 4096);

    // Let any trailing activity settle before the verdict.
    repeat (20) @(posedge clk_i);
    if (errors == 0 && grant_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pba_pkg.sv
rtl/core/paged_bump_allocator_top.sv
dv/testbench.sv
